@@ rtl/weqs_pkg.sv @@
// Shared types, constants and address helpers for the weighted event queue scheduler.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package weqs_pkg;

    localparam int FLOW_SLOTS  = 16;
    localparam int QUEUE_DEPTH = 16;
    localparam int NUM_KINDS   = 3;

    localparam int FLOW_W   = $clog2(FLOW_SLOTS);
    localparam int QIDX_W   = $clog2(QUEUE_DEPTH);
    localparam int KIND_W   = 2;
    localparam int WEIGHT_W = 4;
    localparam int PROD_W   = WEIGHT_W + QIDX_W;
    localparam int TYPE_W   = 8;
    localparam int VALUE_W  = 32;
    localparam int EVENT_W  = TYPE_W + VALUE_W;
    localparam int OP_W     = 3;
    localparam int STATUS_W = 2;
    localparam int CFG_AW   = 2;

    localparam int EV_DEPTH = FLOW_SLOTS * NUM_KINDS * QUEUE_DEPTH;
    localparam int EV_AW    = $clog2(EV_DEPTH);
    localparam int MARKS    = FLOW_SLOTS * QUEUE_DEPTH;
    localparam int MARK_W   = FLOW_W + QIDX_W;

    localparam logic [QIDX_W-1:0] FULL_COUNT = QIDX_W'(QUEUE_DEPTH - 1);

    localparam logic [OP_W-1:0] OP_ENQ_PROG  = 3'd0;
    localparam logic [OP_W-1:0] OP_ENQ_TIMER = 3'd1;
    localparam logic [OP_W-1:0] OP_WR_APP    = 3'd2;
    localparam logic [OP_W-1:0] OP_SET_TAIL  = 3'd3;
    localparam logic [OP_W-1:0] OP_SCHED     = 3'd4;

    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_TIM_INV = 2'd3;

    localparam logic [KIND_W-1:0] KIND_APP   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TIMER = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PROG  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NONE  = 2'd3;

    localparam logic [CFG_AW-1:0] CFG_APP_WEIGHT   = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_TIMER_WEIGHT = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_PROG_WEIGHT  = 2'd2;

    localparam logic [WEIGHT_W-1:0] APP_WEIGHT_RST   = 4'd1;
    localparam logic [WEIGHT_W-1:0] TIMER_WEIGHT_RST = 4'd3;
    localparam logic [WEIGHT_W-1:0] PROG_WEIGHT_RST  = 4'd2;

    typedef struct packed {
        logic [QIDX_W-1:0] head;
        logic [QIDX_W-1:0] tail;
        logic [QIDX_W-1:0] count;
    } t_ring;

    typedef t_ring [NUM_KINDS-1:0] t_ring_row;

    typedef struct packed {
        logic              none;
        logic [KIND_W-1:0] kind;
    } t_pick;

    function automatic logic [QIDX_W-1:0] next_pos(input logic [QIDX_W-1:0] p);
        return (p == FULL_COUNT) ? '0 : p + QIDX_W'(1);
    endfunction

    function automatic logic [EV_AW-1:0] ev_addr(input logic [FLOW_W-1:0] flow,
                                                 input logic [KIND_W-1:0] kind,
                                                 input logic [QIDX_W-1:0] pos);
        logic [EV_AW-1:0] ring;
        ring = EV_AW'(flow) * EV_AW'(NUM_KINDS) + EV_AW'(kind);
        return EV_AW'(ring * EV_AW'(QUEUE_DEPTH)) + EV_AW'(pos);
    endfunction

endpackage

@@ rtl/weqs_ring_table.sv @@
// Ring control memory: head, tail and count of all three rings of one flow per row.
// Row valid flops make unwritten rows read as zero. Depends on weqs_pkg.
`timescale 1ns / 1ps

module weqs_ring_table (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_rd_en,
    input  logic [weqs_pkg::FLOW_W-1:0]    i_rd_addr,
    output weqs_pkg::t_ring_row            o_rd_row,
    input  logic                           i_wr_en,
    input  logic [weqs_pkg::FLOW_W-1:0]    i_wr_addr,
    input  weqs_pkg::t_ring_row            i_wr_row
);

    weqs_pkg::t_ring_row               mem [weqs_pkg::FLOW_SLOTS];
    logic [weqs_pkg::FLOW_SLOTS-1:0]   r_row_ok;
    weqs_pkg::t_ring_row               r_rd_data;
    logic                              r_rd_ok;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_row;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_ok <= '0;
            r_rd_ok  <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_row_ok[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_ok <= r_row_ok[i_rd_addr];
            end
        end
    end

    assign o_rd_row = r_rd_ok ? r_rd_data : '0;

endmodule

@@ rtl/weqs_event_ram.sv @@
// Event store (type and value per ring entry) and the timer entry valid marks.
// Store has a registered read; marks reset to zero. Depends on weqs_pkg.
`timescale 1ns / 1ps

module weqs_event_ram (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_wr_en,
    input  logic [weqs_pkg::EV_AW-1:0]     i_wr_addr,
    input  logic [weqs_pkg::EVENT_W-1:0]   i_wr_data,
    input  logic                           i_rd_en,
    input  logic [weqs_pkg::EV_AW-1:0]     i_rd_addr,
    output logic [weqs_pkg::EVENT_W-1:0]   o_rd_data,
    input  logic [weqs_pkg::MARK_W-1:0]    i_mark_idx,
    input  logic                           i_mark_set,
    input  logic                           i_mark_clr,
    output logic                           o_mark
);

    logic [weqs_pkg::EVENT_W-1:0]  mem [weqs_pkg::EV_DEPTH];
    logic [weqs_pkg::EVENT_W-1:0]  r_rd_data;
    logic [weqs_pkg::MARKS-1:0]    r_marks;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marks <= '0;
        end else if (i_mark_set) begin
            r_marks[i_mark_idx] <= 1'b1;
        end else if (i_mark_clr) begin
            r_marks[i_mark_idx] <= 1'b0;
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_mark    = r_marks[i_mark_idx];

endmodule

@@ rtl/weqs_pick.sv @@
// Weighted pick: scale each ring count by its weight and choose the strictly largest.
// Ties go to the lower kind; all-zero reports none. Depends on weqs_pkg.
`timescale 1ns / 1ps

module weqs_pick (
    input  weqs_pkg::t_ring_row              i_row,
    input  logic [weqs_pkg::WEIGHT_W-1:0]    i_app_w,
    input  logic [weqs_pkg::WEIGHT_W-1:0]    i_tim_w,
    input  logic [weqs_pkg::WEIGHT_W-1:0]    i_prg_w,
    output weqs_pkg::t_pick                  o_pick
);

    logic [weqs_pkg::PROD_W-1:0] w_app;
    logic [weqs_pkg::PROD_W-1:0] w_tim;
    logic [weqs_pkg::PROD_W-1:0] w_prg;
    logic [weqs_pkg::PROD_W-1:0] best;

    assign w_app = weqs_pkg::PROD_W'(i_app_w) * weqs_pkg::PROD_W'(i_row[weqs_pkg::KIND_APP].count);
    assign w_tim = weqs_pkg::PROD_W'(i_tim_w) *
                   weqs_pkg::PROD_W'(i_row[weqs_pkg::KIND_TIMER].count);
    assign w_prg = weqs_pkg::PROD_W'(i_prg_w) *
                   weqs_pkg::PROD_W'(i_row[weqs_pkg::KIND_PROG].count);

    always_comb begin
        best        = w_app;
        o_pick.none = 1'b0;
        o_pick.kind = weqs_pkg::KIND_APP;
        if (w_tim > best) begin
            best        = w_tim;
            o_pick.kind = weqs_pkg::KIND_TIMER;
        end
        if (w_prg > best) begin
            best        = w_prg;
            o_pick.kind = weqs_pkg::KIND_PROG;
        end
        if (best == '0) begin
            o_pick.none = 1'b1;
            o_pick.kind = weqs_pkg::KIND_NONE;
        end
    end

endmodule

@@ rtl/weighted_event_queue_scheduler.sv @@
// Weighted event queue scheduler top level: command sequencer over ring and event memories.
// Result strobe is registered from the execute state, or from the fetch state for a dequeuing schedule.
// One item at a time: ring control read, then event read for a schedule that dequeues an event.
// busy drops as the result shows, so the next item is taken in that cycle; no output stall.
// Reset (synchronous, active low): ring rows and timer marks read as zero, weights 1, 3, 2.
// Depends on weqs_pkg, weqs_ring_table, weqs_event_ram and weqs_pick.
`timescale 1ns / 1ps

module weighted_event_queue_scheduler (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [weqs_pkg::CFG_AW-1:0]      i_cfg_addr,
    input  logic [weqs_pkg::WEIGHT_W-1:0]    i_cfg_wdata,
    input  logic                             start,
    output logic                             busy,
    input  logic [2:0]                       i_opcode,
    input  logic [3:0]                       i_flow_slot,
    input  logic [3:0]                       i_entry_index,
    input  logic [7:0]                       i_event_type,
    input  logic [31:0]                      i_event_value,
    output logic                             o_done,
    output logic [1:0]                       o_status,
    output logic [1:0]                       o_queue_kind,
    output logic [7:0]                       o_out_event_type,
    output logic [31:0]                      o_out_event_value,
    output logic [3:0]                       o_queue_length
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_FETCH = 2'd2;

    logic [1:0]                        r_state;
    logic [1:0]                        n_state;
    logic [weqs_pkg::OP_W-1:0]         r_op;
    logic [weqs_pkg::FLOW_W-1:0]       r_flow;
    logic [weqs_pkg::QIDX_W-1:0]       r_idx;
    logic [weqs_pkg::TYPE_W-1:0]       r_etype;
    logic [weqs_pkg::VALUE_W-1:0]      r_evalue;
    logic [weqs_pkg::KIND_W-1:0]       r_kind;
    logic [weqs_pkg::KIND_W-1:0]       n_kind;
    logic [weqs_pkg::QIDX_W-1:0]       r_len;
    logic [weqs_pkg::QIDX_W-1:0]       n_len;
    logic [weqs_pkg::STATUS_W-1:0]     n_status;
    logic [weqs_pkg::WEIGHT_W-1:0]     r_app_w;
    logic [weqs_pkg::WEIGHT_W-1:0]     r_tim_w;
    logic [weqs_pkg::WEIGHT_W-1:0]     r_prg_w;

    logic                              r_done;
    logic [weqs_pkg::STATUS_W-1:0]     r_o_status;
    logic [weqs_pkg::KIND_W-1:0]       r_o_kind;
    logic [weqs_pkg::TYPE_W-1:0]       r_o_type;
    logic [weqs_pkg::VALUE_W-1:0]      r_o_value;
    logic [weqs_pkg::QIDX_W-1:0]       r_o_len;

    logic                              accept;
    weqs_pkg::t_ring_row               row;
    weqs_pkg::t_ring_row               n_row;
    weqs_pkg::t_ring                   cur;
    weqs_pkg::t_pick                   pick;
    logic                              ring_we;
    logic                              ev_we;
    logic [weqs_pkg::EV_AW-1:0]        ev_waddr;
    logic                              ev_re;
    logic [weqs_pkg::EV_AW-1:0]        ev_raddr;
    logic [weqs_pkg::EVENT_W-1:0]      ev_rdata;
    logic [weqs_pkg::MARK_W-1:0]       mark_idx;
    logic                              mark_set;
    logic                              mark_clr;
    logic                              mark;
    logic                              res_now;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);

    weqs_ring_table u_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (i_flow_slot[weqs_pkg::FLOW_W-1:0]),
        .o_rd_row  (row),
        .i_wr_en   (ring_we),
        .i_wr_addr (r_flow),
        .i_wr_row  (n_row)
    );

    weqs_event_ram u_event (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (ev_we),
        .i_wr_addr  (ev_waddr),
        .i_wr_data  ({r_etype, r_evalue}),
        .i_rd_en    (ev_re),
        .i_rd_addr  (ev_raddr),
        .o_rd_data  (ev_rdata),
        .i_mark_idx (mark_idx),
        .i_mark_set (mark_set),
        .i_mark_clr (mark_clr),
        .o_mark     (mark)
    );

    weqs_pick u_pick (
        .i_row   (row),
        .i_app_w (r_app_w),
        .i_tim_w (r_tim_w),
        .i_prg_w (r_prg_w),
        .o_pick  (pick)
    );

    // Timer mark: tail for a timer enqueue, head for a schedule.
    assign mark_idx = (r_op == weqs_pkg::OP_ENQ_TIMER) ?
                      {r_flow, row[weqs_pkg::KIND_TIMER].tail} :
                      {r_flow, row[weqs_pkg::KIND_TIMER].head};

    always_comb begin
        n_state  = r_state;
        n_row    = row;
        n_kind   = weqs_pkg::KIND_NONE;
        n_len    = '0;
        n_status = weqs_pkg::ST_DONE;
        cur      = row[weqs_pkg::KIND_APP];
        ring_we  = 1'b0;
        ev_we    = 1'b0;
        ev_waddr = weqs_pkg::ev_addr(r_flow, weqs_pkg::KIND_APP, r_idx);
        ev_re    = 1'b0;
        ev_raddr = weqs_pkg::ev_addr(r_flow, weqs_pkg::KIND_APP, r_idx);
        mark_set = 1'b0;
        mark_clr = 1'b0;
        res_now  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                res_now = 1'b1;
                n_state = S_IDLE;
                case (r_op) inside
                    weqs_pkg::OP_ENQ_PROG, weqs_pkg::OP_ENQ_TIMER: begin
                        n_kind = (r_op == weqs_pkg::OP_ENQ_PROG) ? weqs_pkg::KIND_PROG :
                                                                    weqs_pkg::KIND_TIMER;
                        cur    = row[n_kind];
                        if (cur.count == weqs_pkg::FULL_COUNT) begin
                            n_status = weqs_pkg::ST_FULL;
                            n_len    = cur.count;
                        end else begin
                            ev_we          = 1'b1;
                            ev_waddr       = weqs_pkg::ev_addr(r_flow, n_kind, cur.tail);
                            mark_set       = (n_kind == weqs_pkg::KIND_TIMER);
                            cur.tail       = weqs_pkg::next_pos(cur.tail);
                            cur.count      = cur.count + weqs_pkg::QIDX_W'(1);
                            n_row[n_kind]  = cur;
                            ring_we        = 1'b1;
                            n_len          = cur.count;
                        end
                    end
                    weqs_pkg::OP_WR_APP: begin
                        ev_we  = 1'b1;
                        n_kind = weqs_pkg::KIND_APP;
                        n_len  = row[weqs_pkg::KIND_APP].count;
                    end
                    weqs_pkg::OP_SET_TAIL: begin
                        cur.tail  = r_idx;
                        cur.count = r_idx - cur.head;
                        n_row[weqs_pkg::KIND_APP] = cur;
                        ring_we   = 1'b1;
                        n_kind    = weqs_pkg::KIND_APP;
                        n_len     = cur.count;
                    end
                    weqs_pkg::OP_SCHED: begin
                        if (pick.none) begin
                            n_status = weqs_pkg::ST_EMPTY;
                        end else begin
                            n_kind = pick.kind;
                            cur    = row[pick.kind];
                            if (pick.kind == weqs_pkg::KIND_TIMER && !mark) begin
                                n_status = weqs_pkg::ST_TIM_INV;
                                n_len    = cur.count;
                            end else begin
                                mark_clr        = (pick.kind == weqs_pkg::KIND_TIMER);
                                ev_re           = 1'b1;
                                ev_raddr = weqs_pkg::ev_addr(r_flow, pick.kind, cur.head);
                                cur.head        = weqs_pkg::next_pos(cur.head);
                                cur.count       = cur.count - weqs_pkg::QIDX_W'(1);
                                n_row[pick.kind] = cur;
                                ring_we         = 1'b1;
                                n_len           = cur.count;
                                res_now         = 1'b0;
                                n_state         = S_FETCH;
                            end
                        end
                    end
                    default: begin
                        n_kind = weqs_pkg::KIND_NONE;
                    end
                endcase
            end
            S_FETCH: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_app_w <= weqs_pkg::APP_WEIGHT_RST;
            r_tim_w <= weqs_pkg::TIMER_WEIGHT_RST;
            r_prg_w <= weqs_pkg::PROG_WEIGHT_RST;
        end else begin
            r_state <= n_state;
            r_done  <= res_now || (r_state == S_FETCH);
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    weqs_pkg::CFG_APP_WEIGHT:   r_app_w <= i_cfg_wdata;
                    weqs_pkg::CFG_TIMER_WEIGHT: r_tim_w <= i_cfg_wdata;
                    weqs_pkg::CFG_PROG_WEIGHT:  r_prg_w <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op     <= i_opcode;
            r_flow   <= i_flow_slot[weqs_pkg::FLOW_W-1:0];
            r_idx    <= i_entry_index[weqs_pkg::QIDX_W-1:0];
            r_etype  <= i_event_type;
            r_evalue <= i_event_value;
        end
        if (r_state == S_EXEC) begin
            r_kind <= n_kind;
            r_len  <= n_len;
        end
        if (res_now) begin
            r_o_status <= n_status;
            r_o_kind   <= n_kind;
            r_o_type   <= '0;
            r_o_value  <= '0;
            r_o_len    <= n_len;
        end else if (r_state == S_FETCH) begin
            r_o_status <= weqs_pkg::ST_DONE;
            r_o_kind   <= r_kind;
            r_o_type   <= ev_rdata[weqs_pkg::EVENT_W-1:weqs_pkg::VALUE_W];
            r_o_value  <= ev_rdata[weqs_pkg::VALUE_W-1:0];
            r_o_len    <= r_len;
        end
    end

    assign o_done            = r_done;
    assign o_status          = r_o_status;
    assign o_queue_kind      = r_o_kind;
    assign o_out_event_type  = r_o_type;
    assign o_out_event_value = r_o_value;
    assign o_queue_length    = 4'(r_o_len);

    a_done_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without an item in work");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy && !o_done)
        else $error("accepted item did not enter execution");

    a_fetch_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FETCH |-> $past(r_state) == S_EXEC && $past(ring_we))
        else $error("event fetch without a ring update");

    a_none_zero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_queue_kind == weqs_pkg::KIND_NONE |-> o_queue_length == 4'd0
            && o_out_event_type == 8'd0)
        else $error("result with no queue carries a length or event");

endmodule
